// File: rtl/core/integer_to_radix_text_core_macros.svh
// Assertion macros for the integer-to-radix-text core.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef INTEGER_TO_RADIX_TEXT_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_CORE_MACROS_SVH

// check a condition in the same cycle as its trigger
`define ITRT_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("itrt assertion failed");

// check a condition in the cycle after its trigger
`define ITRT_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("itrt assertion failed");

`endif

// File: rtl/core/itrt_pkg.sv
// Shared constants, types and helper functions of the integer-to-radix-text core.
// No dependencies.
`default_nettype none

package itrt_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;
	localparam int DIV_STEPS      = 4;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_AW       = 1;
	localparam int QUEUE_CW       = 2;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] DECIMAL     = 6'd10;
	localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd35;

	localparam logic [CHAR_W-1:0] CHAR_MINUS      = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO       = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE       = 7'h39;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 7'h5A;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'h37;

	localparam logic [ADDR_W-3:0] REG_RADIX = 1'b0;

	typedef struct packed {
		logic                 minus;
		logic [RADIX_W-1:0]   base;
	} job_ctl_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN) begin
			return RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			return RADIX_MAX;
		end else begin
			return r;
		end
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [RADIX_W-1:0] c;
		c = (d > DIGIT_MAX) ? DIGIT_MAX : d;
		if (c < DECIMAL) begin
			return CHAR_ZERO + {1'b0, c};
		end else begin
			return CHAR_ALPHA_BASE + {1'b0, c};
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/itrt_front.sv
// Front end: radix register, item intake, sign and radix classification.
// Depends on itrt_pkg.
`default_nettype none

module itrt_front #(
	parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [itrt_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [itrt_pkg::DATA_W-1:0]     pwdata,
	output      logic [itrt_pkg::DATA_W-1:0]     prdata,
	output      logic                            pready,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic signed [VALUE_BITS-1:0]    value,
	output      logic                            push,
	input  wire logic                            push_ready,
	output      itrt_pkg::job_ctl_t              push_ctl,
	output      logic [VALUE_BITS-1:0]           push_mag
);

	logic [itrt_pkg::RADIX_W-1:0] radix_q;
	logic [itrt_pkg::ADDR_W-3:0]  reg_idx;
	logic [itrt_pkg::RADIX_W-1:0] base;
	logic [VALUE_BITS-1:0]        raw;
	logic                         neg;

	assign reg_idx = paddr[itrt_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itrt_pkg::RADIX_RESET;
		end else if (psel && penable && pwrite && reg_idx == itrt_pkg::REG_RADIX) begin
			radix_q <= pwdata[itrt_pkg::RADIX_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == itrt_pkg::REG_RADIX) begin
			prdata[itrt_pkg::RADIX_W-1:0] = radix_q;
		end
	end

	assign base     = itrt_pkg::eff_radix(radix_q);
	assign raw      = $unsigned(value);
	assign neg      = raw[VALUE_BITS-1] && (base == itrt_pkg::DECIMAL);
	assign in_ready = push_ready;
	assign push     = in_valid && push_ready;

	assign push_ctl.minus = neg;
	assign push_ctl.base  = base;
	assign push_mag       = neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

endmodule

`default_nettype wire

// File: rtl/core/itrt_queue.sv
// Two-entry job queue between the front end and the conversion engine.
// Depends on itrt_pkg.
`default_nettype none

module itrt_queue #(
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	output      logic          wr_ready,
	input  wire logic [DW-1:0] wr_data,
	output      logic          rd_valid,
	input  wire logic          rd_en,
	output      logic [DW-1:0] rd_data
);

	logic [DW-1:0]                   slot_q [itrt_pkg::QUEUE_DEPTH];
	logic [itrt_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [itrt_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [itrt_pkg::QUEUE_CW-1:0]   cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign wr_ready = (cnt_q != itrt_pkg::QUEUE_CW'(itrt_pkg::QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/itrt_back.sv
// Conversion engine: iterative radix division into a digit memory, then
// character emission most significant first through an output register.
// Depends on itrt_pkg.
`default_nettype none

module itrt_back #(
	parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          job_valid,
	output      logic                          job_ready,
	input  wire itrt_pkg::job_ctl_t            job_ctl,
	input  wire logic [VALUE_BITS-1:0]         job_mag,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [itrt_pkg::CHAR_W-1:0]   text_char,
	output      logic                          last_char
);

	localparam int BPC = itrt_pkg::DIV_STEPS;
	localparam int PW  = ((VALUE_BITS + BPC - 1) / BPC) * BPC;
	localparam int CPD = PW / BPC;
	localparam int CW  = (CPD > 1) ? $clog2(CPD) : 1;
	localparam int AW  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int RW  = itrt_pkg::RADIX_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;

	logic [2:0]                  state_q;
	logic [PW-1:0]               dq_q;
	logic [RW-1:0]               rem_q;
	logic [CW-1:0]               cyc_q;
	logic [AW-1:0]               wr_idx_q;
	logic [AW-1:0]               rd_idx_q;
	logic                        minus_q;
	logic [RW-1:0]               base_q;
	logic [RW-1:0]               rd_q;
	logic [RW-1:0]               digit_mem [VALUE_BITS];
	logic                        out_valid_q;
	logic [itrt_pkg::CHAR_W-1:0] char_q;
	logic                        last_q;

	logic [RW-1:0]               rem_next;
	logic [BPC-1:0]              qbits;
	logic [PW-1:0]               dq_next;
	logic                        digit_done;
	logic                        out_free;
	logic                        load_sign;
	logic                        load_digit;

	always_comb begin
		logic [RW:0]   t;
		logic [RW-1:0] r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < BPC; i++) begin
			t = {r, dq_q[PW-1-i]};
			if (t >= {1'b0, base_q}) begin
				t = t - {1'b0, base_q};
				qbits[BPC-1-i] = 1'b1;
			end
			r = t[RW-1:0];
		end
		rem_next = r;
		dq_next  = {dq_q[PW-BPC-1:0], qbits};
	end

	assign digit_done = (state_q == ST_DIV) && (cyc_q == CW'(CPD - 1));
	assign out_free   = !out_valid_q || out_ready;
	assign load_sign  = (state_q == ST_SIGN) && out_free;
	assign load_digit = (state_q == ST_LOAD) && out_free;
	assign job_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (digit_done) begin
			digit_mem[wr_idx_q] <= rem_next;
		end
		if (state_q == ST_READ) begin
			rd_q <= digit_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			dq_q    <= PW'(job_mag);
			minus_q <= job_ctl.minus;
			base_q  <= job_ctl.base;
		end else if (state_q == ST_DIV) begin
			dq_q <= dq_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rem_q    <= '0;
			cyc_q    <= '0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						rem_q    <= '0;
						cyc_q    <= '0;
						wr_idx_q <= '0;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						rem_q <= '0;
						cyc_q <= '0;
						if (dq_next == '0) begin
							rd_idx_q <= wr_idx_q;
							state_q  <= minus_q ? ST_SIGN : ST_READ;
						end else begin
							wr_idx_q <= wr_idx_q + 1'b1;
						end
					end else begin
						rem_q <= rem_next;
						cyc_q <= cyc_q + 1'b1;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_sign || load_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sign) begin
			char_q <= itrt_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (load_digit) begin
			char_q <= itrt_pkg::digit_char(rd_q);
			last_q <= (rd_idx_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;

endmodule

`default_nettype wire

// File: rtl/core/integer_to_radix_text_core.sv
// Integer to radix text: one signed value in, its ASCII digits out, MSD first.
// The 4-bit-per-cycle divider writes each digit into a digit memory; the engine then loads an
// optional minus sign and, per digit, reads the memory (ST_READ) and loads the output register (ST_LOAD).
// The engine takes a new item only once its last character is loaded, and out_ready stalls hold it;
// a two-entry queue holds waiting items.
// Reset: asynchronous, clears control state and the queue, radix returns to 10; no clearing pass.
`default_nettype none

`include "integer_to_radix_text_core_macros.svh"

module integer_to_radix_text_core #(
	parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [itrt_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [itrt_pkg::DATA_W-1:0]   pwdata,
	output      logic [itrt_pkg::DATA_W-1:0]   prdata,
	output      logic                          pready,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic signed [VALUE_BITS-1:0]  value,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [itrt_pkg::CHAR_W-1:0]   text_char,
	output      logic                          last_char
);

	localparam int CTL_W = $bits(itrt_pkg::job_ctl_t);
	localparam int JW    = CTL_W + VALUE_BITS;

	logic                 push;
	logic                 push_ready;
	itrt_pkg::job_ctl_t   push_ctl;
	logic [VALUE_BITS-1:0] push_mag;
	logic                 job_valid;
	logic                 job_ready;
	logic [JW-1:0]        job_data;
	itrt_pkg::job_ctl_t   job_ctl;
	logic                 char_legal;

	itrt_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.push      (push),
		.push_ready(push_ready),
		.push_ctl  (push_ctl),
		.push_mag  (push_mag)
	);

	itrt_queue #(
		.DW(JW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_ready(push_ready),
		.wr_data ({push_ctl, push_mag}),
		.rd_valid(job_valid),
		.rd_en   (job_ready),
		.rd_data (job_data)
	);

	assign job_ctl = itrt_pkg::job_ctl_t'(job_data[JW-1:VALUE_BITS]);

	itrt_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_ctl  (job_ctl),
		.job_mag  (job_data[VALUE_BITS-1:0]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.text_char(text_char),
		.last_char(last_char)
	);

	assign char_legal =
		(text_char >= itrt_pkg::CHAR_ZERO && text_char <= itrt_pkg::CHAR_NINE) ||
		(text_char >= itrt_pkg::CHAR_UPPER_A && text_char <= itrt_pkg::CHAR_UPPER_Z) ||
		(text_char == itrt_pkg::CHAR_MINUS);

	`ITRT_ASSERT_NEXT(a_push_queued, in_valid && in_ready, job_valid)
	`ITRT_ASSERT_SAME(a_minus_not_last, out_valid && text_char == itrt_pkg::CHAR_MINUS, !last_char)
	`ITRT_ASSERT_SAME(a_char_legal, out_valid, char_legal)

endmodule

`default_nettype wire

// File: tb/integer_to_radix_text_checker.sv
// Checker for the integer-to-radix-text core: follows radix writes on the APB port,
// renders every accepted value into its expected characters and compares the output stream.
// Depends on itrt_pkg.
module integer_to_radix_text_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic                          pready,
	input  wire logic [itrt_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [itrt_pkg::DATA_W-1:0]   pwdata,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [31:0]                   value,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [itrt_pkg::CHAR_W-1:0]   text_char,
	input  wire logic                          last_char,
	output int                                 errors,
	output int                                 outstanding,
	output int                                 numbers,
	output int                                 chars
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [itrt_pkg::CHAR_W-1:0] code;
		logic                        last;
	} text_item_t;

	text_item_t                   char_q[$];
	logic [itrt_pkg::RADIX_W-1:0] radix_reg;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic void render_digits(input logic [31:0] v);
		logic [itrt_pkg::RADIX_W-1:0] base;
		logic [31:0]                  base_w;
		logic [31:0]                  mag;
		logic [itrt_pkg::RADIX_W-1:0] digit [32];
		logic [itrt_pkg::CHAR_W-1:0]  code;
		int                           n;
		base = (radix_reg < itrt_pkg::RADIX_MIN) ? itrt_pkg::RADIX_MIN :
			(radix_reg > itrt_pkg::RADIX_MAX) ? itrt_pkg::RADIX_MAX : radix_reg;
		base_w = 32'(base);
		mag = v;
		n = 0;
		if (base == itrt_pkg::DECIMAL && v[31]) begin
			mag = -v;
			char_q.push_back('{code: itrt_pkg::CHAR_MINUS, last: 1'b0});
		end
		do begin
			digit[n] = itrt_pkg::RADIX_W'(mag % base_w);
			mag = mag / base_w;
			n++;
		end while (mag != 0 && n < 32);
		for (int k = n - 1; k >= 0; k--) begin
			if (digit[k] < itrt_pkg::DECIMAL) begin
				code = itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(digit[k]);
			end else begin
				code = itrt_pkg::CHAR_UPPER_A +
					itrt_pkg::CHAR_W'(digit[k] - itrt_pkg::DECIMAL);
			end
			char_q.push_back('{code: code, last: (k == 0)});
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_item_t want;
		if (!arst_n) begin
			radix_reg = itrt_pkg::RADIX_RESET;
			char_q.delete();
		end else begin
			if (psel && penable && pwrite && pready &&
				paddr[itrt_pkg::ADDR_W-1:2] == itrt_pkg::REG_RADIX) begin
				radix_reg = pwdata[itrt_pkg::RADIX_W-1:0];
			end
			if (in_valid && in_ready) begin
				render_digits(value);
				numbers++;
			end
			if (out_valid && out_ready) begin
				chars++;
				if (char_q.size() == 0) begin
					report_mismatch($sformatf("unexpected character %h", text_char));
				end else begin
					want = char_q.pop_front();
					if (text_char !== want.code) begin
						report_mismatch($sformatf("text_char %h, expected %h",
							text_char, want.code));
					end
					if (last_char !== want.last) begin
						report_mismatch($sformatf("last_char %b, expected %b",
							last_char, want.last));
					end
				end
			end
		end
		outstanding = char_q.size();
	end

endmodule

// File: tb/integer_to_radix_text_core_tb.sv
// Top of the integer-to-radix-text testbench: clock, reset, radix writes and value stimulus.
// Depends on itrt_pkg, integer_to_radix_text_core and integer_to_radix_text_checker.
module integer_to_radix_text_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [itrt_pkg::ADDR_W-3:0] REG_SPARE = 1'b1;
	localparam int IDLE_PCT = 11;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [itrt_pkg::ADDR_W-1:0]   paddr;
	logic [itrt_pkg::DATA_W-1:0]   pwdata;
	logic [itrt_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [31:0]            value;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [itrt_pkg::CHAR_W-1:0]   text_char;
	logic                          last_char;
	bit                            calm = 1'b0;
	int                            errors;
	int                            outstanding;
	int                            numbers;
	int                            chars;
	int                            settings = 0;

	integer_to_radix_text_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.text_char (text_char),
		.last_char (last_char)
	);

	integer_to_radix_text_checker text_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.text_char   (text_char),
		.last_char   (last_char),
		.errors      (errors),
		.outstanding (outstanding),
		.numbers     (numbers),
		.chars       (chars)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(5))
		0: v = $urandom_range(40);
		1: v = -32'($urandom_range(40));
		2: v = 32'h8000_0000 + $urandom_range(3);
		3: v = (32'd1 << $urandom_range(31)) - $urandom_range(1);
		default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [itrt_pkg::ADDR_W-3:0] index,
		input logic [itrt_pkg::DATA_W-1:0] data);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		settings++;
	endtask

	task automatic send_value(input logic [31:0] v);
		int   gap;
		logic ok;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
	endtask

	initial begin
		logic [itrt_pkg::RADIX_W-1:0] r;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset radix is decimal: signs, extremes and digit-count boundaries
		send_value(32'd0);
		send_value(32'hFFFF_FFFF);
		send_value(32'd1);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd9);
		send_value(32'd10);
		send_value(-32'd10);

		write_reg(itrt_pkg::REG_RADIX, 32'(itrt_pkg::RADIX_MIN));
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd0);

		write_reg(itrt_pkg::REG_RADIX, 32'd16);
		send_value(32'hDEAD_BEEF);
		send_value(32'h1234_5678);

		write_reg(itrt_pkg::REG_RADIX, 32'(itrt_pkg::RADIX_MAX));
		send_value(32'hFFFF_FFFF);
		send_value(32'd35);
		send_value(32'd36);

		// write to an unmapped register must leave the radix alone
		write_reg(REG_SPARE, 32'd5);
		send_value(32'd71);

		// out-of-range radices clamp to the nearest legal base
		write_reg(itrt_pkg::REG_RADIX, 32'd0);
		send_value(32'd5);
		write_reg(itrt_pkg::REG_RADIX, 32'd1);
		send_value(-32'd6);
		write_reg(itrt_pkg::REG_RADIX, 32'd37);
		send_value(32'd36);
		write_reg(itrt_pkg::REG_RADIX, 32'hFFFF_FFFF);
		send_value(32'd1295);

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
			0: r = itrt_pkg::RADIX_MIN;
			1: r = itrt_pkg::RADIX_MAX;
			2: r = itrt_pkg::DECIMAL;
			5: r = itrt_pkg::RADIX_W'($urandom_range(63));
			default: r = itrt_pkg::RADIX_W'($urandom_range(itrt_pkg::RADIX_MAX,
				itrt_pkg::RADIX_MIN));
			endcase
			write_reg(itrt_pkg::REG_RADIX, ($urandom() & ~32'h3F) | 32'(r));
			calm = (phase == 3);
			repeat (27) send_value(pick_value());
		end
		calm = 1'b0;

		wait_drained();
		$display("covered %0d numbers and %0d characters over %0d register writes",
			numbers, chars, settings);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/itrt_pkg.sv
rtl/core/itrt_front.sv
rtl/core/itrt_queue.sv
rtl/core/itrt_back.sv
rtl/core/integer_to_radix_text_core.sv
tb/integer_to_radix_text_checker.sv
tb/integer_to_radix_text_core_tb.sv
